>>> src/pmtfx_pkg.sv
`timescale 1ns / 1ps

package pmtfx_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH     = 2;

  // fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int PEAK_W   = 10;
  localparam int MINV_W   = 12;
  localparam int BASE_W   = 20;
  localparam int AMP_W    = 21;
  localparam int CHG_W    = 31;
  localparam int PRE_W    = 10;
  localparam int WEND_W   = 11;
  localparam int RES_W    = 16;

  // register file
  localparam int ADDR_W   = 4;
  localparam int PDATA_W  = 32;

  localparam logic [PRE_W-1:0]  PRE_RESET  = 10'd96;
  localparam logic [WEND_W-1:0] WEND_RESET = 11'd780;
  localparam logic [RES_W-1:0]  RES_RESET  = 16'd50;

  localparam logic [63:0] CHARGE_LIMIT = 64'd1073741823;

  // divider defaults at the default parameter set
  localparam int DIV_NUM_W_DEF = 41;
  localparam int DIV_DEN_W_DEF = PRE_W + RES_W;

  typedef enum logic [1:0] {
    REG_PRE  = 2'd0,
    REG_WEND = 2'd1,
    REG_RES  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PRE_W-1:0]  pre;
    logic [WEND_W-1:0] wend;
    logic [RES_W-1:0]  res;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PREP,
    BK_DIVB,
    BK_DIVC,
    BK_FIN
  } bk_state_t;

endpackage

>>> src/pmtfx_if.sv
`timescale 1ns / 1ps

interface pmtfx_in_if import pmtfx_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                last_sample;

  modport source (output valid, sample_value, last_sample, input ready);
  modport sink   (input valid, sample_value, last_sample, output ready);
endinterface

interface pmtfx_out_if import pmtfx_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PEAK_W-1:0]        peak_index;
  logic [MINV_W-1:0]        minimum_value;
  logic [BASE_W-1:0]        baseline_fx;
  logic signed [AMP_W-1:0]  amplitude_fx;
  logic signed [CHG_W-1:0]  charge_fx;
  logic                     short_waveform;

  modport source (output valid, peak_index, minimum_value, baseline_fx, amplitude_fx,
                  charge_fx, short_waveform, input ready);
  modport sink   (input valid, peak_index, minimum_value, baseline_fx, amplitude_fx,
                  charge_fx, short_waveform, output ready);
endinterface

>>> src/pmtfx_front.sv
`timescale 1ns / 1ps

module pmtfx_front import pmtfx_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_SAMPLES),
  localparam int SUM_W = SAMPLE_BITS + IDX_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  pmtfx_in_if.sink               in_ch,
  input  logic                   job_full,
  output logic                   job_push,
  output logic [IDX_W-1:0]       job_minidx,
  output logic [SAMPLE_BITS-1:0] job_min,
  output logic [SUM_W-1:0]       job_bsum,
  output logic [SUM_W-1:0]       job_wsum,
  output logic [WEND_W-1:0]      job_nwin,
  output logic                   job_short
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > WEND_W) ? CNT_W : WEND_W;

  logic [CNT_W-1:0]       cnt_r, cnt_nxt, upd_cnt;
  logic [SAMPLE_BITS-1:0] min_r, min_nxt, upd_min;
  logic [IDX_W-1:0]       minidx_r, minidx_nxt, upd_minidx;
  logic [SUM_W-1:0]       bsum_r, bsum_nxt, upd_bsum;
  logic [SUM_W-1:0]       wsum_r, wsum_nxt, upd_wsum;

  logic [31:0]            raw_ext;
  logic [SAMPLE_BITS-1:0] v;
  logic                   fire, active, in_pre, in_win;
  logic [CMP_W-1:0]       cnt_c, pre_c, wend_c, win_hi, win_len;

  assign raw_ext     = 32'(in_ch.sample_value);
  assign v           = raw_ext[SAMPLE_BITS-1:0];
  assign in_ch.ready = !job_full;
  assign fire        = in_ch.valid && in_ch.ready;

  assign active = cnt_r < CNT_W'(MAX_SAMPLES);
  assign pre_c  = CMP_W'(cfg.pre);
  assign wend_c = CMP_W'(cfg.wend);
  assign in_pre = CMP_W'(cnt_r) < pre_c;
  assign in_win = CMP_W'(cnt_r) < wend_c;

  // samples past the maximum leave the state alone
  always_comb begin
    upd_cnt    = cnt_r;
    upd_min    = min_r;
    upd_minidx = minidx_r;
    upd_bsum   = bsum_r;
    upd_wsum   = wsum_r;
    if (active) begin
      if (cnt_r == '0 || v < min_r) begin
        upd_min    = v;
        upd_minidx = cnt_r[IDX_W-1:0];
      end
      if (in_pre) begin
        upd_bsum = bsum_r + SUM_W'(v);
      end else if (in_win) begin
        upd_wsum = wsum_r + SUM_W'(v);
      end
      upd_cnt = cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    min_nxt    = min_r;
    minidx_nxt = minidx_r;
    bsum_nxt   = bsum_r;
    wsum_nxt   = wsum_r;
    if (fire) begin
      if (in_ch.last_sample) begin
        cnt_nxt    = '0;
        min_nxt    = '0;
        minidx_nxt = '0;
        bsum_nxt   = '0;
        wsum_nxt   = '0;
      end else begin
        cnt_nxt    = upd_cnt;
        min_nxt    = upd_min;
        minidx_nxt = upd_minidx;
        bsum_nxt   = upd_bsum;
        wsum_nxt   = upd_wsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      min_r    <= '0;
      minidx_r <= '0;
      bsum_r   <= '0;
      wsum_r   <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      min_r    <= min_nxt;
      minidx_r <= minidx_nxt;
      bsum_r   <= bsum_nxt;
      wsum_r   <= wsum_nxt;
    end
  end

  // number of window samples actually received
  assign cnt_c   = CMP_W'(upd_cnt);
  assign win_hi  = (cnt_c < wend_c) ? cnt_c : wend_c;
  assign win_len = (win_hi > pre_c) ? (win_hi - pre_c) : '0;

  assign job_push   = fire && in_ch.last_sample;
  assign job_minidx = upd_minidx;
  assign job_min    = upd_min;
  assign job_bsum   = upd_bsum;
  assign job_wsum   = upd_wsum;
  assign job_nwin   = win_len[WEND_W-1:0];
  assign job_short  = (cnt_c < wend_c) || (cnt_c < pre_c);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond maximum");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_ch.last_sample |=> cnt_r == '0 && bsum_r == '0 && wsum_r == '0)
    else $error("waveform state not cleared after last sample");

endmodule

>>> src/pmtfx_fifo.sv
`timescale 1ns / 1ps

module pmtfx_fifo import pmtfx_pkg::*; #(
  parameter int DATA_W = 1,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("job queue overflow");

endmodule

>>> src/pmtfx_div.sv
`timescale 1ns / 1ps

module pmtfx_div import pmtfx_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W_DEF,
  parameter int DEN_W = DIV_DEN_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt, den_r;
  logic [DEN_W:0]   sh, diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign sh      = {rem_r, q_r[NUM_W-1]};
  assign diff    = sh - {1'b0, den_r};
  assign ge      = sh >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
  assign q_nxt   = {q_r[NUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

>>> src/pmtfx_back.sv
`timescale 1ns / 1ps

module pmtfx_back import pmtfx_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_SAMPLES),
  localparam int SUM_W = SAMPLE_BITS + IDX_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   job_empty,
  output logic                   job_pop,
  input  logic [IDX_W-1:0]       job_minidx,
  input  logic [SAMPLE_BITS-1:0] job_min,
  input  logic [SUM_W-1:0]       job_bsum,
  input  logic [SUM_W-1:0]       job_wsum,
  input  logic [WEND_W-1:0]      job_nwin,
  input  logic                   job_short,
  pmtfx_out_if.source            out_ch
);

  localparam int PROD_W = SUM_W + WEND_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int DEN_W  = PRE_W + RES_W;
  localparam int BQ_W   = SUM_W + FRAC_BITS;
  localparam int AMPX_W = (BQ_W + 1 > AMP_W) ? BQ_W + 1 : AMP_W;
  localparam int SAT_W  = CHG_W - 1;

  bk_state_t st_r, st_nxt;

  logic [IDX_W-1:0]       j_minidx_r;
  logic [SAMPLE_BITS-1:0] j_min_r;
  logic [SUM_W-1:0]       j_bsum_r, j_wsum_r;
  logic [WEND_W-1:0]      j_nwin_r;
  logic                   j_short_r;

  logic [PRE_W-1:0]         pe;
  logic [SUM_W+PRE_W-1:0]   pos_w;
  logic [WEND_W+SUM_W-1:0]  neg_w;
  logic [DEN_W-1:0]         den_w;
  logic [PROD_W-1:0]        pos_r, neg_r, mag_r;
  logic [DEN_W-1:0]         den_r;
  logic                     neg_flag_r;
  logic [BQ_W-1:0]          base_q_r;
  logic [SAT_W-1:0]         sat_r;

  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num, div_q;
  logic [DEN_W-1:0] div_den;
  logic             out_load;

  logic [63:0]             peak_x, min_x, base_x;
  logic [AMPX_W-1:0]       amp_x;
  logic [CHG_W-1:0]        chg_mag, chg_val;

  logic                    out_valid_r;
  logic [PEAK_W-1:0]       out_peak_r;
  logic [MINV_W-1:0]       out_min_r;
  logic [BASE_W-1:0]       out_base_r;
  logic [AMP_W-1:0]        out_amp_r;
  logic [CHG_W-1:0]        out_chg_r;
  logic                    out_short_r;

  // a zero pre-trigger leaves the baseline sum at zero, so dividing by one is exact
  assign pe    = (cfg.pre == '0) ? PRE_W'(1) : cfg.pre;
  assign pos_w = j_wsum_r * pe;
  assign neg_w = j_nwin_r * j_bsum_r;
  assign den_w = pe * cfg.res;

  pmtfx_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (!job_empty) st_nxt = BK_MUL;
      BK_MUL:  st_nxt = BK_PREP;
      BK_PREP: st_nxt = BK_DIVB;
      BK_DIVB: if (div_done) st_nxt = BK_DIVC;
      BK_DIVC: if (div_done) st_nxt = BK_FIN;
      BK_FIN:  if (!out_valid_r || out_ch.ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop   = 1'b0;
    div_start = 1'b0;
    div_num   = NUM_W'(j_bsum_r) << FRAC_BITS;
    div_den   = DEN_W'(pe);
    out_load  = 1'b0;
    unique case (st_r)
      BK_IDLE: job_pop = !job_empty;
      BK_PREP: div_start = 1'b1;
      BK_DIVB: begin
        div_start = div_done;
        div_num   = NUM_W'(mag_r) << FRAC_BITS;
        div_den   = den_r;
      end
      BK_FIN:  out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      j_minidx_r <= job_minidx;
      j_min_r    <= job_min;
      j_bsum_r   <= job_bsum;
      j_wsum_r   <= job_wsum;
      j_nwin_r   <= job_nwin;
      j_short_r  <= job_short;
    end
    if (st_r == BK_MUL) begin
      pos_r <= PROD_W'(pos_w);
      neg_r <= PROD_W'(neg_w);
      den_r <= den_w;
    end
    if (st_r == BK_PREP) begin
      neg_flag_r <= neg_r > pos_r;
      mag_r      <= (neg_r > pos_r) ? (neg_r - pos_r) : (pos_r - neg_r);
    end
    if (st_r == BK_DIVB && div_done) begin
      base_q_r <= div_q[BQ_W-1:0];
    end
    if (st_r == BK_DIVC && div_done) begin
      sat_r <= (64'(div_q) > CHARGE_LIMIT) ? SAT_W'(CHARGE_LIMIT) : SAT_W'(div_q);
    end
  end

  // result fields, each cut to its width
  assign peak_x  = 64'(j_minidx_r);
  assign min_x   = 64'(j_min_r);
  assign base_x  = 64'(base_q_r);
  assign amp_x   = AMPX_W'(base_q_r) - (AMPX_W'(j_min_r) << FRAC_BITS);
  assign chg_mag = {1'b0, sat_r};
  assign chg_val = (cfg.res == '0) ? '0 : (neg_flag_r ? (CHG_W'(0) - chg_mag) : chg_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_peak_r  <= peak_x[PEAK_W-1:0];
      out_min_r   <= min_x[MINV_W-1:0];
      out_base_r  <= base_x[BASE_W-1:0];
      out_amp_r   <= amp_x[AMP_W-1:0];
      out_chg_r   <= chg_val;
      out_short_r <= j_short_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.peak_index     = out_peak_r;
  assign out_ch.minimum_value  = out_min_r;
  assign out_ch.baseline_fx    = out_base_r;
  assign out_ch.amplitude_fx   = $signed(out_amp_r);
  assign out_ch.charge_fx      = $signed(out_chg_r);
  assign out_ch.short_waveform = out_short_r;

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && st_r == BK_IDLE)
    else $error("result not presented after final step");

  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> st_r == BK_DIVB || st_r == BK_DIVC)
    else $error("divider running outside a division step");

endmodule

>>> src/pmt_waveform_feature_extract.sv
`timescale 1ns / 1ps

// Photomultiplier waveform feature extractor.
// in_ch carries one ADC sample per transfer with a last flag; the transfer that
// carries the last flag closes the waveform and yields exactly one result on out_ch
// (peak index, minimum, baseline, amplitude, charge, short flag).
// Samples are taken one per cycle: the front accumulates min, baseline and window
// sums as each sample arrives and only stalls when its two-entry job queue is full.
// The back pulls one waveform at a time from the queue, forms the products, then
// runs the baseline and charge divisions on one shared bit-serial divider. That
// divider sets the per-waveform cost; the back takes the next waveform from the
// queue only once the result of the last one is loaded into the output register.
// Results wait in an output register; while out_ch stalls the back holds its
// finished result, the queue fills, and in_ch.ready drops once the queue is full.
// Configuration is written over the APB port (pre-trigger length at 0x0, window end
// at 0x4, load resistance at 0x8); the user must write it only while no waveform
// is in flight, and the block itself does not enforce this.
// Synchronous reset clears the accumulators, the queue and the output register and
// restores the default register values; there is no initialization sweep.
module pmt_waveform_feature_extract import pmtfx_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  pmtfx_in_if.sink           in_ch,
  pmtfx_out_if.source        out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int JOB_W = IDX_W + SAMPLE_BITS + 2 * SUM_W + WEND_W + 1;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre  <= PRE_RESET;
      cfg_r.wend <= WEND_RESET;
      cfg_r.res  <= RES_RESET;
    end else if (wr_en) begin
      unique case (paddr[ADDR_W-1:2])
        REG_PRE:  cfg_r.pre  <= pwdata[PRE_W-1:0];
        REG_WEND: cfg_r.wend <= pwdata[WEND_W-1:0];
        REG_RES:  cfg_r.res  <= pwdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[ADDR_W-1:2])
      REG_PRE:  prdata = PDATA_W'(cfg_r.pre);
      REG_WEND: prdata = PDATA_W'(cfg_r.wend);
      REG_RES:  prdata = PDATA_W'(cfg_r.res);
      default:  prdata = '0;
    endcase
  end

  logic                   f_push, q_full, q_empty, b_pop;
  logic [IDX_W-1:0]       f_minidx, q_minidx;
  logic [SAMPLE_BITS-1:0] f_min, q_min;
  logic [SUM_W-1:0]       f_bsum, f_wsum, q_bsum, q_wsum;
  logic [WEND_W-1:0]      f_nwin, q_nwin;
  logic                   f_short, q_short;
  logic [JOB_W-1:0]       q_wr, q_rd;

  pmtfx_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .job_full   (q_full),
    .job_push   (f_push),
    .job_minidx (f_minidx),
    .job_min    (f_min),
    .job_bsum   (f_bsum),
    .job_wsum   (f_wsum),
    .job_nwin   (f_nwin),
    .job_short  (f_short)
  );

  assign q_wr = {f_minidx, f_min, f_bsum, f_wsum, f_nwin, f_short};
  assign {q_minidx, q_min, q_bsum, q_wsum, q_nwin, q_short} = q_rd;

  pmtfx_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (b_pop),
    .rd_data (q_rd),
    .empty   (q_empty)
  );

  pmtfx_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .job_empty  (q_empty),
    .job_pop    (b_pop),
    .job_minidx (q_minidx),
    .job_min    (q_min),
    .job_bsum   (q_bsum),
    .job_wsum   (q_wsum),
    .job_nwin   (q_nwin),
    .job_short  (q_short),
    .out_ch     (out_ch)
  );

endmodule
